// ----- src/vhd_pkg.sv -----
// Shared constants, types and the arctangent table for the vector heading block.
`timescale 1ns / 1ps

package vhd_pkg;

	// Default configuration.
	localparam int DEF_ITERATIONS  = 16;
	localparam int DEF_COORD_WIDTH = 16;

	// Number of arctangent entries available.
	localparam int TABLE_LEN = 24;

	// CORDIC operands are scaled up by this many bits before the iterations.
	localparam int PRESHIFT = 24;

	// Headroom bits above the scaled magnitude: one for the sign, one for the gain.
	localparam int XGUARD = 2;

	// Angle widths: table entries, signed accumulator and full-circle angle.
	localparam int ANG_W = 23;
	localparam int ZW    = ANG_W + 2;
	localparam int TW    = 25;

	// Output heading width and rounding to 1/64 degree from degrees * 65536.
	localparam int HEAD_W      = 15;
	localparam int ROUND_SHIFT = 10;

	localparam logic [TW-1:0] ROUND_HALF = TW'(512);
	localparam logic [TW-1:0] ANG_90     = TW'(90 * 65536);
	localparam logic [TW-1:0] ANG_180    = TW'(180 * 65536);
	localparam logic [TW-1:0] ANG_360    = TW'(360 * 65536);
	localparam logic [HEAD_W-1:0] HEAD_FULL_TURN = HEAD_W'(360 * 64);

	// atan(2^-i) in degrees * 65536, rounded to nearest.
	localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
		23'd234379,  23'd117304,  23'd58666,  23'd29335,
		23'd14668,   23'd7334,    23'd3667,   23'd1833,
		23'd917,     23'd458,     23'd229,    23'd115,
		23'd57,      23'd29,      23'd14,     23'd7,
		23'd4,       23'd2,       23'd1,      23'd0
	};

	// Per-item side information that travels beside the CORDIC data.
	typedef struct packed {
		logic zero;    // start equals end
		logic horiz;   // vertical difference is zero
		logic vert;    // horizontal difference is zero
		logic u_neg;   // vector points down the screen
		logic dx_neg;  // vector points left
	} vhd_flags_t;

endpackage

// ----- src/vhd_if.sv -----
// Valid/ready channel interfaces for point pairs in and headings out.
`timescale 1ns / 1ps

interface vhd_in_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface vhd_out_if;
	import vhd_pkg::*;
	logic              valid;
	logic              ready;
	logic [HEAD_W-1:0] heading;
	logic              zero_vector;

	modport source (output valid, heading, zero_vector, input ready);
	modport sink   (input valid, heading, zero_vector, output ready);
endinterface

// ----- src/vector_heading_degrees_top.sv -----
// Top level: pipelined CORDIC heading of a point-to-point vector in 1/64 degree.
//
// Usage: each request on pts carries a start and an end point in signed Q12.4
// pixels, y pointing down. The block returns on hdg the counterclockwise
// heading of end minus start, measured from +x with y taken as up, over
// [0, 360) degrees in units of 1/64 degree. A zero-length vector gives
// heading 0 with zero_vector set.
// Stages from acceptance to hdg: one difference stage, one magnitude stage,
// one stage per CORDIC iteration, a quadrant stage and a rounding stage.
// Throughput: one request per cycle, sustained while hdg results are taken.
// Each stage has its own valid bit and is loaded whenever it is empty or the
// stage after it moves, so bubbles close up while the output is held.
// pts.ready drops only when every stage holds a request and hdg is stalled;
// a stalled result stays on hdg unchanged until taken.
// Reset clears all valid bits; the pipeline is empty and ready right away.
`timescale 1ns / 1ps

module vector_heading_degrees_top
	import vhd_pkg::*;
#(
	parameter int CORDIC_ITERATIONS = DEF_ITERATIONS,
	parameter int COORD_WIDTH       = DEF_COORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	vhd_in_if.sink    pts,
	vhd_out_if.source hdg
);

	localparam int NIT = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
	localparam int DW  = COORD_WIDTH + 1;
	localparam int XW  = DW + PRESHIFT + XGUARD;
	localparam int NST = NIT + 4;
	localparam int MAP = NIT + 2;
	localparam int OUT = NIT + 3;

	// Stage valid bits and per-stage load enables.
	logic [NST-1:0] vld_sk;
	logic [NST-1:0] rdy;

	// Stage 1: coordinate differences.
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] u_s1;

	// Magnitude stage and CORDIC stages; index 0 is the magnitude stage.
	logic signed [XW-1:0] x_sk  [NIT+1];
	logic signed [XW-1:0] y_sk  [NIT+1];
	logic signed [ZW-1:0] z_sk  [NIT+1];
	vhd_flags_t           fl_sk [NIT+1];

	// Quadrant stage and output stage.
	logic [TW-1:0]     t_sm;
	vhd_flags_t        fl_sm;
	logic [HEAD_W-1:0] head_so;
	logic              zero_so;

	logic [DW-1:0]     ax;
	logic [DW-1:0]     au;
	vhd_flags_t        fl_new;
	logic [TW-1:0]     a_clamp;
	logic [TW-1:0]     a_sel;
	logic [TW-1:0]     t_new;
	logic [TW-1:0]     t_round;
	logic [HEAD_W-1:0] h_new;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		rdy[NST-1] = !vld_sk[NST-1] || hdg.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			rdy[k] = !vld_sk[k] || rdy[k+1];
		end
	end

	assign pts.ready = rdy[0];

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else begin
			if (rdy[0]) begin
				vld_sk[0] <= pts.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					vld_sk[k] <= vld_sk[k-1];
				end
			end
		end
	end

	// Stage 1: dx = end_x - start_x, u = start_y - end_y (y flipped to point up).
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			dx_s1 <= {pts.end_x[COORD_WIDTH-1], pts.end_x}
				- {pts.start_x[COORD_WIDTH-1], pts.start_x};
			u_s1  <= {pts.start_y[COORD_WIDTH-1], pts.start_y}
				- {pts.end_y[COORD_WIDTH-1], pts.end_y};
		end
	end

	// Magnitudes and the special-case flags.
	assign ax = dx_s1[DW-1] ? (~dx_s1 + 1'b1) : dx_s1;
	assign au = u_s1[DW-1] ? (~u_s1 + 1'b1) : u_s1;

	always_comb begin
		fl_new.horiz  = (u_s1 == '0);
		fl_new.vert   = (dx_s1 == '0);
		fl_new.zero   = fl_new.horiz && fl_new.vert;
		fl_new.u_neg  = u_s1[DW-1];
		fl_new.dx_neg = dx_s1[DW-1];
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			x_sk[0]  <= {{XGUARD{1'b0}}, ax, {PRESHIFT{1'b0}}};
			y_sk[0]  <= {{XGUARD{1'b0}}, au, {PRESHIFT{1'b0}}};
			z_sk[0]  <= '0;
			fl_sk[0] <= fl_new;
		end
	end

	// One CORDIC vectoring iteration per stage; shifts round toward minus infinity.
	for (genvar i = 0; i < NIT; i++) begin : g_iter
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		logic signed [ZW-1:0] step;

		assign xs   = x_sk[i] >>> i;
		assign ys   = y_sk[i] >>> i;
		assign step = signed'({2'b00, ATAN_TAB[i]});

		always_ff @(posedge clk) begin
			if (rdy[i+2]) begin
				if (!y_sk[i][XW-1]) begin
					x_sk[i+1] <= x_sk[i] + ys;
					y_sk[i+1] <= y_sk[i] - xs;
					z_sk[i+1] <= z_sk[i] + step;
				end else begin
					x_sk[i+1] <= x_sk[i] - ys;
					y_sk[i+1] <= y_sk[i] + xs;
					z_sk[i+1] <= z_sk[i] - step;
				end
				fl_sk[i+1] <= fl_sk[i];
			end
		end
	end

	// Clamp to the first quadrant, apply the axis cases, then unfold the quadrant.
	always_comb begin
		if (z_sk[NIT][ZW-1]) begin
			a_clamp = '0;
		end else if (z_sk[NIT] > $signed(ANG_90)) begin
			a_clamp = ANG_90;
		end else begin
			a_clamp = TW'(z_sk[NIT]);
		end

		if (fl_sk[NIT].horiz) begin
			a_sel = '0;
		end else if (fl_sk[NIT].vert) begin
			a_sel = ANG_90;
		end else begin
			a_sel = a_clamp;
		end

		if (!fl_sk[NIT].u_neg) begin
			t_new = fl_sk[NIT].dx_neg ? (ANG_180 - a_sel) : a_sel;
		end else begin
			t_new = fl_sk[NIT].dx_neg ? (ANG_180 + a_sel) : (ANG_360 - a_sel);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[MAP]) begin
			t_sm  <= t_new;
			fl_sm <= fl_sk[NIT];
		end
	end

	// Round half up to 1/64 degree, wrap a full turn to zero and give zero for a zero-length vector.
	assign t_round = t_sm + ROUND_HALF;
	assign h_new   = t_round[TW-1:ROUND_SHIFT];

	always_ff @(posedge clk) begin
		if (rdy[OUT]) begin
			head_so <= (fl_sm.zero || h_new >= HEAD_FULL_TURN) ? '0 : h_new;
			zero_so <= fl_sm.zero;
		end
	end

	assign hdg.valid       = vld_sk[OUT];
	assign hdg.heading     = head_so;
	assign hdg.zero_vector = zero_so;

	// A zero-length vector always reports heading zero.
	a_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		hdg.valid && hdg.zero_vector |-> hdg.heading == '0)
		else $error("zero vector with nonzero heading");

	// Headings stay below a full turn.
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdg.valid |-> hdg.heading < HEAD_FULL_TURN)
		else $error("heading out of range");

	// Input is refused only when every stage holds a request and the output stalls.
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pts.ready |-> (&vld_sk) && !hdg.ready)
		else $error("input stalled with an empty pipeline stage");

	// A result that was not taken is still presented in the next cycle.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		hdg.valid && !hdg.ready |=> hdg.valid && $stable(hdg.heading))
		else $error("stalled result lost or changed");

endmodule

// ----- tb/tb_vector_heading_degrees_top.sv -----
// Self-checking testbench for the pipelined vector heading block.
`timescale 1ns / 1ps

module tb_vector_heading_degrees_top;
	import vhd_pkg::*;

	localparam int ITERATIONS = 16;
	localparam int COORD_W    = 16;

	// Angles in degrees * 65536, as the heading is formed before rounding.
	localparam longint DEG_UNIT    = 65536;
	localparam longint DEG_90      = 90 * DEG_UNIT;
	localparam longint DEG_180     = 180 * DEG_UNIT;
	localparam longint DEG_360     = 360 * DEG_UNIT;
	localparam longint FULL_TURN   = 360 * 64;
	localparam int     ARCTAN_LEN  = 24;
	localparam int     OPERAND_SHL = 24;
	localparam int     ITER_USED   = (ITERATIONS > ARCTAN_LEN) ? ARCTAN_LEN : ITERATIONS;
	localparam int     REPORT_MAX  = 10;
	localparam int     RANDOM_REQUESTS = 1250;

	// atan(2^-i) in degrees * 65536, rounded to nearest.
	localparam longint ARCTAN_DEG [ARCTAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} point_pair_t;

	typedef struct {
		point_pair_t       pair;
		logic [HEAD_W-1:0] heading;
		logic              zero_vector;
	} heading_due_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vhd_in_if #(.COORD_WIDTH(COORD_W)) pts_if ();
	vhd_out_if hdg_if ();

	vector_heading_degrees_top #(
		.CORDIC_ITERATIONS(ITERATIONS),
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pts(pts_if),
		.hdg(hdg_if)
	);

	point_pair_t  pairs_to_send [$];
	heading_due_t headings_due [$];
	heading_due_t due_now;
	point_pair_t  taken_pair;

	int unsigned requests_sent;
	int unsigned headings_checked;
	int unsigned zero_headings;
	int unsigned mismatch_count;
	int unsigned in_gap;
	int unsigned out_wait;
	bit          in_no_gaps;
	bit          out_no_gaps;

	always #6 clk = ~clk;

	// First-quadrant angle of two positive magnitudes by CORDIC vectoring.
	function automatic longint cordic_quadrant_angle(longint mag_x, longint mag_y);
		longint x;
		longint y;
		longint z;
		longint x_sh;
		longint y_sh;
		x = mag_x <<< OPERAND_SHL;
		y = mag_y <<< OPERAND_SHL;
		z = 0;
		for (int i = 0; i < ITER_USED; i++) begin
			// Arithmetic shifts of signed values round toward minus infinity.
			x_sh = x >>> i;
			y_sh = y >>> i;
			if (y >= 0) begin
				x = x + y_sh;
				y = y - x_sh;
				z = z + ARCTAN_DEG[i];
			end else begin
				x = x - y_sh;
				y = y + x_sh;
				z = z - ARCTAN_DEG[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > DEG_90)
			z = DEG_90;
		return z;
	endfunction

	// Expected heading of the vector from start to end, y taken as pointing up.
	function automatic heading_due_t predict_heading(point_pair_t p);
		heading_due_t due;
		longint dx;
		longint up;
		longint abs_dx;
		longint abs_up;
		longint angle;
		longint turn;
		longint rounded;
		dx = longint'(p.end_x) - longint'(p.start_x);
		up = longint'(p.start_y) - longint'(p.end_y);
		abs_dx = (dx < 0) ? -dx : dx;
		abs_up = (up < 0) ? -up : up;
		due.pair = p;
		if (dx == 0 && up == 0) begin
			due.heading = '0;
			due.zero_vector = 1'b1;
			return due;
		end
		if (abs_up == 0)
			angle = 0;
		else if (abs_dx == 0)
			angle = DEG_90;
		else
			angle = cordic_quadrant_angle(abs_dx, abs_up);
		// Place the first-quadrant angle in the quadrant of the vector.
		if (up >= 0)
			turn = (dx >= 0) ? angle : DEG_180 - angle;
		else
			turn = (dx < 0) ? DEG_180 + angle : DEG_360 - angle;
		rounded = (turn + 512) >>> 10;
		if (rounded >= FULL_TURN)
			rounded = 0;
		due.heading = HEAD_W'(rounded);
		due.zero_vector = 1'b0;
		return due;
	endfunction

	function automatic int unsigned draw_gap(bit no_gaps);
		if (no_gaps)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	task automatic queue_pair(int sx, int sy, int ex, int ey);
		point_pair_t p;
		p.start_x = COORD_W'(sx);
		p.start_y = COORD_W'(sy);
		p.end_x   = COORD_W'(ex);
		p.end_y   = COORD_W'(ey);
		pairs_to_send.push_back(p);
	endtask

	// Request driver: holds a request until taken, then waits its drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_if.valid   <= 1'b0;
			pts_if.start_x <= '0;
			pts_if.start_y <= '0;
			pts_if.end_x   <= '0;
			pts_if.end_y   <= '0;
			in_gap = 0;
		end else begin
			if (pts_if.valid && pts_if.ready) begin
				taken_pair.start_x = pts_if.start_x;
				taken_pair.start_y = pts_if.start_y;
				taken_pair.end_x   = pts_if.end_x;
				taken_pair.end_y   = pts_if.end_y;
				headings_due.push_back(predict_heading(taken_pair));
				requests_sent++;
				in_gap = draw_gap(in_no_gaps);
				if ($urandom_range(0, 49) == 0)
					in_no_gaps = !in_no_gaps;
			end
			if (pts_if.valid && !pts_if.ready) begin
				// Request still waiting: hold it unchanged.
			end else if (in_gap > 0) begin
				pts_if.valid <= 1'b0;
				in_gap--;
			end else if (pairs_to_send.size() > 0) begin
				pts_if.start_x <= pairs_to_send[0].start_x;
				pts_if.start_y <= pairs_to_send[0].start_y;
				pts_if.end_x   <= pairs_to_send[0].end_x;
				pts_if.end_y   <= pairs_to_send[0].end_y;
				pts_if.valid   <= 1'b1;
				void'(pairs_to_send.pop_front());
			end else begin
				pts_if.valid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each heading against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdg_if.ready <= 1'b0;
			out_wait = 0;
		end else begin
			if (hdg_if.valid && hdg_if.ready) begin
				if (headings_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("Unexpected heading %0d zero_vector %0b with nothing pending",
							hdg_if.heading, hdg_if.zero_vector);
				end else begin
					due_now = headings_due.pop_front();
					headings_checked++;
					if (due_now.zero_vector)
						zero_headings++;
					if (hdg_if.heading !== due_now.heading ||
						hdg_if.zero_vector !== due_now.zero_vector) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("Heading error for (%0d,%0d)->(%0d,%0d): %s %0d/%0b, %s %0d/%0b",
								due_now.pair.start_x, due_now.pair.start_y,
								due_now.pair.end_x, due_now.pair.end_y,
								"expected", due_now.heading, due_now.zero_vector,
								"got", hdg_if.heading, hdg_if.zero_vector);
					end
				end
				out_wait = draw_gap(out_no_gaps);
				if ($urandom_range(0, 49) == 0)
					out_no_gaps = !out_no_gaps;
			end
			if (out_wait > 0) begin
				hdg_if.ready <= 1'b0;
				out_wait--;
			end else begin
				hdg_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int kind;
		int sx;
		int sy;
		int dx;
		int dy;

		// Zero-length vectors, axes, diagonals and the coordinate extremes.
		queue_pair(0, 0, 0, 0);
		queue_pair(32767, -32768, 32767, -32768);
		queue_pair(0, 0, 100, 0);
		queue_pair(0, 0, -100, 0);
		queue_pair(0, 0, 0, -100);
		queue_pair(0, 0, 0, 100);
		queue_pair(0, 0, 16, -16);
		queue_pair(0, 0, -16, -16);
		queue_pair(0, 0, -16, 16);
		queue_pair(0, 0, 16, 16);
		queue_pair(-32768, 0, 32767, 0);
		queue_pair(32767, 0, -32768, 0);
		queue_pair(0, -32768, 0, 32767);
		queue_pair(0, 32767, 0, -32768);
		queue_pair(-32768, -32768, 32767, 32767);
		queue_pair(32767, 32767, -32768, -32768);
		// Just below +x: the heading rounds up to a full turn and wraps to zero.
		queue_pair(-32768, 0, 32767, 1);
		queue_pair(-32768, 1, 32767, 0);
		queue_pair(32767, 0, -32768, -1);
		queue_pair(32767, -1, -32768, 0);
		queue_pair(0, 32767, 1, -32768);
		queue_pair(-1, -1, 0, 0);
		queue_pair(0, 0, -1, 1);
		queue_pair(-32768, -32768, -32768, -32768);

		// Random point pairs weighted toward the cases that stress the angle.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			kind = $urandom_range(0, 99);
			sx = int'($signed(16'($urandom)));
			sy = int'($signed(16'($urandom)));
			if (kind < 35) begin
				dx = $urandom_range(0, 65535);
				dy = $urandom_range(0, 65535);
			end else if (kind < 60) begin
				dx = $urandom_range(0, 128) - 64;
				dy = $urandom_range(0, 128) - 64;
			end else if (kind < 70) begin
				dx = $urandom_range(0, 65535);
				dy = 0;
				if ($urandom_range(0, 1))
					{dx, dy} = {dy, dx};
			end else if (kind < 75) begin
				dx = 0;
				dy = 0;
			end else if (kind < 85) begin
				dx = $urandom_range(1, 32767);
				dy = $urandom_range(0, 1) ? dx : -dx;
				if ($urandom_range(0, 1))
					dx = -dx;
			end else begin
				dx = $urandom_range(0, 65535);
				dy = $urandom_range(0, 6) - 3;
				if ($urandom_range(0, 1))
					{dx, dy} = {dy, dx};
			end
			queue_pair(sx, sy, sx + dx, sy + dy);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pairs_to_send.size() > 0 || pts_if.valid)
			@(posedge clk);
		while (headings_due.size() > 0)
			@(posedge clk);
		repeat (ITERATIONS + 8) @(posedge clk);

		$display("Sent %0d point pairs and checked %0d headings, %0d of them zero-length.",
			requests_sent, headings_checked, zero_headings);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d results disagreed with the prediction.", mismatch_count);
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog for a hung pipeline.
	initial begin
		#4ms;
		$display("Run did not finish in time; %0d headings still pending.", headings_due.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
